// File: rtl/gbe_pkg.sv
package gbe_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = 11;

    typedef logic [AW-1:0] t_addr;
    typedef logic [LW-1:0] t_len;

    localparam t_len CAP_LEN = t_len'(CAPACITY);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_ERASE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_WRITE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEEK,
        S_COPY,
        S_EDIT,
        S_ACCESS,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load_req;
        logic check;
        logic seek_snap;
        logic move_rd;
        logic move_wr;
        logic edit;
        logic access;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_status status;
        logic    is_access;
        logic    at_target;
        logic    gap_empty;
    } t_sts;

endpackage

// File: rtl/gbe_if.sv
interface gbe_in_if;
    import gbe_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    t_len       position;
    logic [7:0] char_in;
    t_len       erase_count;

    modport source (output valid, output req_type, output position, output char_in,
                    output erase_count, input ready);
    modport sink (input valid, input req_type, input position, input char_in,
                  input erase_count, output ready);
endinterface

interface gbe_out_if;
    import gbe_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [1:0] status;
    t_len       text_length;

    modport source (output valid, output char_out, output status, output text_length,
                    input ready);
    modport sink (input valid, input char_out, input status, input text_length,
                  output ready);
endinterface

// File: rtl/gbe_ctrl.sv
module gbe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gbe_pkg::t_sts i_sts,
    output gbe_pkg::t_cmd o_cmd
);
    import gbe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.status != ST_OK) begin
                    n_state = S_RESP;
                end else if (i_sts.is_access) begin
                    n_state = S_ACCESS;
                end else begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                if (i_sts.gap_empty || i_sts.at_target) begin
                    n_state = S_EDIT;
                end else begin
                    n_state = S_COPY;
                end
            end
            S_COPY:   n_state = S_SEEK;
            S_EDIT:   n_state = S_RESP;
            S_ACCESS: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE:   o_cmd.load_req = i_in_valid;
            S_CHECK:  o_cmd.check = 1'b1;
            S_SEEK: begin
                if (i_sts.gap_empty) begin
                    o_cmd.seek_snap = 1'b1;
                end else if (!i_sts.at_target) begin
                    o_cmd.move_rd = 1'b1;
                end
            end
            S_COPY:   o_cmd.move_wr = 1'b1;
            S_EDIT:   o_cmd.edit = 1'b1;
            S_ACCESS: o_cmd.access = 1'b1;
            S_RESP: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default:  ;
        endcase
    end

endmodule

// File: rtl/gbe_datapath.sv
module gbe_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gbe_pkg::t_cmd i_cmd,
    output gbe_pkg::t_sts o_sts,
    input  logic [1:0]    i_req_type,
    input  gbe_pkg::t_len i_position,
    input  logic [7:0]    i_char_in,
    input  gbe_pkg::t_len i_erase_count,
    output logic [7:0]    o_char_out,
    output logic [1:0]    o_status,
    output gbe_pkg::t_len o_text_length
);
    import gbe_pkg::*;

    logic [7:0] r_mem [CAPACITY];
    logic [7:0] r_rd_data;

    t_len       r_gap_start;
    t_len       r_gap_len;
    t_req       r_req;
    t_len       r_pos;
    logic [7:0] r_char;
    t_len       r_cnt;
    t_status    r_chk_status;

    logic [7:0] r_char_out;
    t_status    r_status;
    t_len       r_text_len;

    t_len       text_len;
    logic [LW:0] pos_end;
    t_len       target;
    t_len       phys;
    t_len       gap_end;
    logic       go_right;
    t_status    status;

    logic       mem_we;
    logic       mem_re;
    t_addr      wr_addr;
    t_addr      rd_addr;
    logic [7:0] wr_data;

    assign text_len = CAP_LEN - r_gap_len;
    assign pos_end  = {1'b0, r_pos} + {1'b0, r_cnt};
    assign target   = (r_req == REQ_ERASE) ? pos_end[LW-1:0] : r_pos;
    assign phys     = (r_pos < r_gap_start) ? r_pos : r_pos + r_gap_len;
    assign gap_end  = r_gap_start + r_gap_len;
    assign go_right = (r_gap_start < target);

    always_comb begin
        status = ST_OK;
        unique case (r_req)
            REQ_INSERT: begin
                if (r_pos > text_len) begin
                    status = ST_RANGE;
                end else if (r_gap_len == '0) begin
                    status = ST_FULL;
                end
            end
            REQ_ERASE: begin
                if (pos_end > {1'b0, text_len}) begin
                    status = ST_RANGE;
                end
            end
            REQ_READ, REQ_WRITE: begin
                if (r_pos >= text_len) begin
                    status = ST_RANGE;
                end
            end
            default: status = ST_RANGE;
        endcase
    end

    assign o_sts.status    = status;
    assign o_sts.is_access = (r_req == REQ_READ) || (r_req == REQ_WRITE);
    assign o_sts.at_target = (r_gap_start == target);
    assign o_sts.gap_empty = (r_gap_len == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= t_req'(i_req_type);
            r_pos  <= i_position;
            r_char <= i_char_in;
            r_cnt  <= i_erase_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_start <= '0;
            r_gap_len   <= CAP_LEN;
        end else begin
            priority if (i_cmd.seek_snap) begin
                r_gap_start <= target;
            end else if (i_cmd.move_wr) begin
                r_gap_start <= go_right ? r_gap_start + t_len'(1) : r_gap_start - t_len'(1);
            end else if (i_cmd.edit && (r_req == REQ_INSERT)) begin
                r_gap_start <= r_gap_start + t_len'(1);
                r_gap_len   <= r_gap_len - t_len'(1);
            end else if (i_cmd.edit && (r_req == REQ_ERASE)) begin
                r_gap_start <= r_gap_start - r_cnt;
                r_gap_len   <= r_gap_len + r_cnt;
            end
        end
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_gap_start[AW-1:0];
        wr_data = r_char;
        if (i_cmd.move_wr) begin
            mem_we  = 1'b1;
            wr_addr = go_right ? r_gap_start[AW-1:0] : (gap_end[AW-1:0] - t_addr'(1));
            wr_data = r_rd_data;
        end else if (i_cmd.edit && (r_req == REQ_INSERT)) begin
            mem_we = 1'b1;
        end else if (i_cmd.access && (r_req == REQ_WRITE)) begin
            mem_we  = 1'b1;
            wr_addr = phys[AW-1:0];
        end
    end

    always_comb begin
        mem_re  = 1'b0;
        rd_addr = phys[AW-1:0];
        if (i_cmd.move_rd) begin
            mem_re  = 1'b1;
            rd_addr = go_right ? gap_end[AW-1:0] : (r_gap_start[AW-1:0] - t_addr'(1));
        end else if (i_cmd.access && (r_req == REQ_READ)) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_chk_status <= status;
        end
        if (i_cmd.out_load) begin
            r_char_out <= ((r_req == REQ_READ) && (r_chk_status == ST_OK)) ? r_rd_data : 8'd0;
            r_status   <= r_chk_status;
            r_text_len <= text_len;
        end
    end

    assign o_char_out    = r_char_out;
    assign o_status      = r_status;
    assign o_text_length = r_text_len;

endmodule

// File: rtl/gap_buffer_engine_unit.sv
// After the input transfer, a rejected request goes from the check to the response; a
// read or overwrite goes via check, access and response; an insert or erase goes via
// check, a seek and a copy step per byte the gap moves (one memory read and one write),
// edit and response. New requests are taken from the cycle after a result is loaded.
// Reset is synchronous and active low: the whole store becomes gap and the store
// contents are left as they are, so no clearing pass runs.
module gap_buffer_engine_unit (
    input logic   i_clk,
    input logic   i_rst_n,
    gbe_in_if.sink    i_req,
    gbe_out_if.source o_rsp
);
    import gbe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gbe_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req.req_type),
        .i_position    (i_req.position),
        .i_char_in     (i_req.char_in),
        .i_erase_count (i_req.erase_count),
        .o_char_out    (o_rsp.char_out),
        .o_status      (o_rsp.status),
        .o_text_length (o_rsp.text_length)
    );

endmodule

// File: rtl/gbe_checker.sv
module gbe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [7:0]    i_char_out,
    input logic [1:0]    i_status,
    input gbe_pkg::t_len i_text_length
);
    import gbe_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_out)
            && $stable(i_status) && $stable(i_text_length))
        else $error("Result changed while its transfer was stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("A second request was taken while one was in progress.");

    a_char_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_out != 8'd0) |-> (i_status == ST_OK))
        else $error("Data byte returned with a failing status.");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_text_length == CAP_LEN))
        else $error("Full status reported while the store had room.");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_text_length <= CAP_LEN))
        else $error("Text length exceeds the store capacity.");

endmodule

bind gap_buffer_engine_unit gbe_checker u_gbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_char_out    (o_rsp.char_out),
    .i_status      (o_rsp.status),
    .i_text_length (o_rsp.text_length)
);

// File: test/gap_buffer_engine_unit_tb.sv
`timescale 1ns / 1ps

module gap_buffer_engine_unit_tb;
    import gbe_pkg::*;

    localparam int RANDOM_EDITS = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 10000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [7:0] char_out;
        t_status    status;
        t_len       text_length;
    } t_edit_result;

    logic i_clk;
    logic i_rst_n;

    gbe_in_if  req_if ();
    gbe_out_if rsp_if ();

    gap_buffer_engine_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [7:0]   shadow_mem [CAPACITY];
    int           shadow_gap_start = 0;
    int           shadow_gap_len = CAPACITY;
    t_edit_result pending_results [$];

    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;
    bit hold_request = 1'b0;

    int mismatches = 0;
    int results_checked = 0;
    int req_count [4] = '{0, 0, 0, 0};
    int status_count [4] = '{0, 0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void slide_gap(int target);
        if (shadow_gap_len == 0) begin
            shadow_gap_start = target;
            return;
        end
        while (shadow_gap_start < target) begin
            if (shadow_gap_start + shadow_gap_len < CAPACITY) begin
                shadow_mem[shadow_gap_start] = shadow_mem[shadow_gap_start + shadow_gap_len];
            end
            shadow_gap_start++;
        end
        while (shadow_gap_start > target) begin
            if (shadow_gap_start + shadow_gap_len - 1 < CAPACITY) begin
                shadow_mem[shadow_gap_start + shadow_gap_len - 1] =
                    shadow_mem[shadow_gap_start - 1];
            end
            shadow_gap_start--;
        end
    endfunction

    function automatic t_edit_result apply_edit(t_req rt, int pos, logic [7:0] ch, int cnt);
        t_edit_result res;
        int len;
        int phys;
        len = CAPACITY - shadow_gap_len;
        res.char_out = 8'h00;
        res.status = ST_OK;
        case (rt)
            REQ_INSERT: begin
                if (pos > len) begin
                    res.status = ST_RANGE;
                end else if (shadow_gap_len == 0) begin
                    res.status = ST_FULL;
                end else begin
                    slide_gap(pos);
                    shadow_mem[shadow_gap_start] = ch;
                    shadow_gap_start++;
                    shadow_gap_len--;
                end
            end
            REQ_ERASE: begin
                if (pos + cnt > len) begin
                    res.status = ST_RANGE;
                end else begin
                    slide_gap(pos + cnt);
                    shadow_gap_start -= cnt;
                    shadow_gap_len += cnt;
                end
            end
            default: begin
                phys = (pos < shadow_gap_start) ? pos : pos + shadow_gap_len;
                if (pos >= len) begin
                    res.status = ST_RANGE;
                end else if (rt == REQ_READ) begin
                    res.char_out = shadow_mem[phys];
                end else begin
                    shadow_mem[phys] = ch;
                end
            end
        endcase
        res.text_length = t_len'(CAPACITY - shadow_gap_len);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic send_request(input t_req rt, input t_len pos, input logic [7:0] ch,
                                input t_len cnt);
        int gap;
        gap = src_idle ? $urandom_range(13, 0) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= rt;
        req_if.position <= pos;
        req_if.char_in <= ch;
        req_if.erase_count <= cnt;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.push_back(apply_edit(rt, int'(pos), ch, int'(cnt)));
        req_count[rt]++;
    endtask

    task automatic send_random_edit();
        int len;
        int lo;
        int hi;
        int roll;
        t_req rt;
        t_len pos;
        t_len cnt;
        len = CAPACITY - shadow_gap_len;
        roll = $urandom_range(99, 0);
        if (roll < 35) begin
            rt = REQ_INSERT;
        end else if (roll < 55) begin
            rt = REQ_ERASE;
        end else if (roll < 80) begin
            rt = REQ_READ;
        end else begin
            rt = REQ_WRITE;
        end
        lo = (shadow_gap_start > 8) ? shadow_gap_start - 8 : 0;
        hi = (shadow_gap_start + 8 < len) ? shadow_gap_start + 8 : len;
        roll = $urandom_range(99, 0);
        if (roll < 75) begin
            pos = t_len'($urandom_range(hi, lo));
        end else if (roll < 90) begin
            pos = t_len'($urandom_range(len, 0));
        end else begin
            pos = t_len'($urandom_range(2047, 0));
        end
        roll = $urandom_range(99, 0);
        if (roll < 70) begin
            cnt = t_len'($urandom_range(6, 0));
        end else if (roll < 90) begin
            cnt = t_len'($urandom_range(64, 0));
        end else begin
            cnt = t_len'($urandom_range(2047, 0));
        end
        send_request(rt, pos, 8'($urandom_range(255, 0)), cnt);
    endtask

    task automatic test_directed();
        send_request(REQ_READ, 0, 8'h00, 0);
        send_request(REQ_WRITE, 0, 8'hFF, 0);
        send_request(REQ_ERASE, 0, 8'h00, 0);
        send_request(REQ_ERASE, 0, 8'h00, 1);
        send_request(REQ_INSERT, 1, 8'h11, 0);
        send_request(REQ_INSERT, 0, 8'h00, 0);
        send_request(REQ_INSERT, 1, 8'hFF, 0);
        send_request(REQ_INSERT, 0, 8'hA5, 0);
        send_request(REQ_INSERT, 2, 8'h5A, 11'h7FF);
        send_request(REQ_READ, 0, 8'h00, 0);
        send_request(REQ_READ, 1, 8'h00, 0);
        send_request(REQ_READ, 2, 8'h00, 0);
        send_request(REQ_READ, 3, 8'h00, 0);
        send_request(REQ_WRITE, 3, 8'hC3, 0);
        send_request(REQ_WRITE, 4, 8'h77, 0);
        send_request(REQ_READ, 4, 8'h00, 0);
        send_request(REQ_READ, 3, 8'h00, 0);
        send_request(REQ_ERASE, 1, 8'h00, 2);
        send_request(REQ_ERASE, 1, 8'h00, 2);
        send_request(REQ_ERASE, 0, 8'h00, 11'h7FF);
        send_request(REQ_INSERT, 11'h7FF, 8'h01, 0);
        send_request(REQ_READ, 11'h7FF, 8'hFF, 11'h7FF);
        send_request(REQ_ERASE, 2, 8'h00, 0);
        send_request(REQ_READ, 1, 8'h00, 0);
        send_request(REQ_ERASE, 0, 8'h00, 2);
        send_request(REQ_READ, 0, 8'h00, 0);
    endtask

    task automatic test_fill();
        int len;
        int i;
        len = CAPACITY - shadow_gap_len;
        while (len < CAPACITY) begin
            src_idle = !(len >= 400 && len < 700);
            snk_idle = src_idle;
            send_request(REQ_INSERT, t_len'(len), 8'($urandom_range(255, 0)),
                         t_len'($urandom_range(2047, 0)));
            len = CAPACITY - shadow_gap_len;
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_request(REQ_INSERT, t_len'($urandom_range(CAPACITY, 0)), 8'h42, 0);
        send_request(REQ_INSERT, t_len'(CAPACITY), 8'h42, 0);
        send_request(REQ_INSERT, t_len'(CAPACITY + 1), 8'h42, 0);
        send_request(REQ_READ, t_len'(CAPACITY - 1), 8'h00, 0);
        send_request(REQ_WRITE, t_len'(CAPACITY - 1), 8'h3C, 0);
        send_request(REQ_READ, t_len'(CAPACITY - 1), 8'h00, 0);
        send_request(REQ_READ, t_len'(CAPACITY), 8'h00, 0);
        send_request(REQ_ERASE, 0, 8'h00, 0);
        send_request(REQ_INSERT, 0, 8'h42, 0);
        send_request(REQ_ERASE, t_len'($urandom_range(CAPACITY, 0)), 8'h00, 0);
        send_request(REQ_ERASE, 1, 8'h00, t_len'(CAPACITY));
        for (i = 0; i < 16; i++) begin
            send_request(REQ_READ, t_len'($urandom_range(CAPACITY - 1, 0)), 8'h00, 0);
        end
        send_request(REQ_ERASE, t_len'($urandom_range(300, 100)), 8'h00, 500);
    endtask

    task automatic test_random_edits();
        int i;
        for (i = 0; i < RANDOM_EDITS; i++) begin
            src_idle = !(i >= 200 && i < 300);
            snk_idle = src_idle;
            send_random_edit();
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        int i;
        hold_request = 1'b1;
        src_idle = 1'b0;
        for (i = 0; i < 12; i++) begin
            send_random_edit();
        end
        src_idle = 1'b1;
    endtask

    initial begin : rsp_sink
        int stall;
        t_edit_result want;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = snk_idle ? $urandom_range(13, 0) : 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending (status %0d)",
                                          rsp_if.status));
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.char_out !== want.char_out) begin
                    report_mismatch($sformatf("result %0d char_out %0h, expected %0h",
                                              results_checked, rsp_if.char_out,
                                              want.char_out));
                end
                if (rsp_if.status !== want.status) begin
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_checked, rsp_if.status, want.status));
                end
                if (rsp_if.text_length !== want.text_length) begin
                    report_mismatch($sformatf("result %0d text_length %0d, expected %0d",
                                              results_checked, rsp_if.text_length,
                                              want.text_length));
                end
                status_count[want.status]++;
                results_checked++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.req_type <= REQ_INSERT;
        req_if.position <= '0;
        req_if.char_in <= 8'h00;
        req_if.erase_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill();
        test_random_edits();
        test_backpressure();

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d inserts, %0d erases, %0d reads, %0d overwrites.",
                 results_checked, req_count[REQ_INSERT], req_count[REQ_ERASE],
                 req_count[REQ_READ], req_count[REQ_WRITE]);
        $display("Outcomes: %0d ok, %0d out of range, %0d full; %0d mismatches.",
                 status_count[ST_OK], status_count[ST_RANGE], status_count[ST_FULL],
                 mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/gbe_pkg.sv
rtl/gbe_if.sv
rtl/gbe_ctrl.sv
rtl/gbe_datapath.sv
rtl/gap_buffer_engine_unit.sv
rtl/gbe_checker.sv
test/gap_buffer_engine_unit_tb.sv
